/* hw/rtl/note_tone_synth_envelope_defines.svh */
// Assertion macros shared by the checker of the note synthesizer voice.
`ifndef NOTE_TONE_SYNTH_ENVELOPE_DEFINES_SVH
`define NOTE_TONE_SYNTH_ENVELOPE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("note synth check failed");

// The consequent must hold in the cycle after the antecedent.
`define NTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("note synth check failed");

`endif

/* hw/rtl/nts_pkg.sv */
// Types, constants and the sine table generator of the note synthesizer voice.
package nts_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned SamplesPerMsDefault   = 16;
  localparam int unsigned MaxNoteSamplesDefault = 32000;
  localparam int unsigned PeakAmplitudeDefault  = 9000;
  localparam int unsigned SineTableBitsDefault  = 10;

  // Fixed widths of the item fields and internal values.
  localparam int unsigned LenW    = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned AmpW    = 14;
  localparam int unsigned PaW     = 29;
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = 16;
  localparam int unsigned InDataW = 152;

  // Noise generator and envelope constants.
  localparam logic [31:0]      NoiseSeed = 32'h0123_4567;
  localparam logic [31:0]      LcgMul    = 32'd1664525;
  localparam logic [31:0]      LcgAdd    = 32'd1013904223;
  localparam logic [LenW-1:0]  AttackCap = 16'd64;
  localparam logic [PctW-1:0]  PctFull   = 7'd100;
  localparam logic [PctW-1:0]  DivThird  = 7'd3;
  // 32768 * 10000: Q15 scale times the two percent scales.
  localparam logic [PaW-1:0]   DenScale  = 29'd327680000;

  // Q2.30 constants of the sine series.
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint OneQ30    = 64'sd1073741824;

  typedef enum logic [2:0] {
    WAVE_SQUARE   = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_NOISE    = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_RING     = 3'd4
  } wave_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  // round(32768 * sin(pi/2 * k / q)) with q = 2^(table_bits-2), by a
  // Taylor series in Q2.30; evaluated at elaboration only. Each term is the
  // previous one times x^2 over (2j)(2j+1).
  function automatic logic [MagW-1:0] quarter_sine(int unsigned k,
                                                    int unsigned table_bits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    int unsigned sh;
    sh   = table_bits - 2;
    x    = (HalfPiQ30 * longint'(k)) >>> sh;
    x2   = (x * x) / OneQ30;
    term = x;
    sum  = x;
    term = -(((term * x2) / OneQ30) / 64'sd6);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd20);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd42);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd72);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd110);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd156);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd210);
    sum  = sum + term;
    term = -(((term * x2) / OneQ30) / 64'sd272);
    sum  = sum + term;
    if (sum < 0) sum = 0;
    if (sum > OneQ30) sum = OneQ30;
    return MagW'((sum + 16384) / 32768);
  endfunction

endpackage

/* hw/rtl/note_tone_synth_envelope.sv */
// Note synthesizer voice: waveform generator, linear envelope and serial divider.
//
// A start item (tuser 0) loads one note and gives no result; it occupies the
// block while the release length is worked out. A tick item (tuser 1) gives
// one sample, computed while a note plays and silent when idle. The release
// length and each note sample come from the shared restoring divider, which
// produces one quotient bit per cycle over a 64-bit dividend; before it, the
// states S_ROMC, S_ROMM, S_SHAPE, S_MULA and S_MULB read the sine ROM
// (registered, 2^(SINE_TABLE_BITS-2)+1 entries, one read for the carrier and one
// for the modulator), shape the wave and form the two products. A finished sample
// sits in the output register, and the next item may be accepted while it waits.
module note_tone_synth_envelope #(
  parameter int unsigned SAMPLES_PER_MS   = nts_pkg::SamplesPerMsDefault,
  parameter int unsigned MAX_NOTE_SAMPLES = nts_pkg::MaxNoteSamplesDefault,
  parameter int unsigned PEAK_AMPLITUDE   = nts_pkg::PeakAmplitudeDefault,
  parameter int unsigned SINE_TABLE_BITS  = nts_pkg::SineTableBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // waveform, carrier_increment, sweep_delta, modulator_increment,
  // base_freq_hz, duration_ms, level, volume, decay_percent
  input  logic [nts_pkg::InDataW-1:0] s_axis_tdata_i,
  // mode
  input  logic                        s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // sample
  output logic [nts_pkg::SampleW-1:0] m_axis_tdata_o,
  // note_active
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);
  import nts_pkg::*;

  localparam int unsigned SineQ     = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned SineDepth = SineQ + 1;
  localparam int unsigned SineAddrW = SINE_TABLE_BITS - 1;
  localparam int unsigned NRawW     = LenW + PctW;
  localparam int unsigned DivW      = 64;
  localparam int unsigned CntW      = $clog2(DivW);
  localparam logic [LenW-1:0] MaxN  = LenW'(MAX_NOTE_SAMPLES);
  localparam logic [PaW-1:0]  Peak  = PaW'(PEAK_AMPLITUDE);
  localparam logic [MagW-1:0] FullScale = 16'h8000;
  localparam logic [MagW-1:0] PosLimit  = 16'h7FFF;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_REL   = 10'b00_0000_0010,
    S_ROMC  = 10'b00_0000_0100,
    S_ROMM  = 10'b00_0000_1000,
    S_SHAPE = 10'b00_0001_0000,
    S_MULA  = 10'b00_0010_0000,
    S_MULB  = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_RELW  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Input fields.
  logic [2:0]      in_wave;
  logic [31:0]     in_carrier, in_sweep, in_mod;
  logic [15:0]     in_base, in_dur;
  logic [PctW-1:0] in_level, in_volume, in_decay;

  assign in_wave    = s_axis_tdata_i[2:0];
  assign in_carrier = s_axis_tdata_i[34:3];
  assign in_sweep   = s_axis_tdata_i[66:35];
  assign in_mod     = s_axis_tdata_i[98:67];
  assign in_base    = s_axis_tdata_i[114:99];
  assign in_dur     = s_axis_tdata_i[130:115];
  assign in_level   = s_axis_tdata_i[137:131];
  assign in_volume  = s_axis_tdata_i[144:138];
  assign in_decay   = s_axis_tdata_i[151:145];

  // Note state.
  logic [31:0]     ph_c_q, ph_m_q, inc_q, sweep_q, mstep_q, noise_q;
  logic [LenW-1:0] idx_q, len_q, att_q, rel_q;
  logic [AmpW-1:0] amp_q;
  logic [PctW-1:0] dp_q;
  logic [2:0]      wave_q;
  logic            playing_q;

  // Per-sample working registers.
  logic [31:0]     smp_c_q, smp_m_q;
  logic [LenW-1:0] e_q, d_q;
  logic            last_q, idle_tick_q, job_rel_q;
  logic [MagW-1:0] rom_q, sinc_q, w_mag_q;
  logic            w_neg_q;
  logic [31:0]     prod_a_q;
  logic [PaW-1:0]  pa_q;
  logic [DivW-1:0] acc_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;

  // Output register.
  logic               m_valid_q, m_user_q, m_last_q;
  logic [SampleW-1:0] m_data_q;

  logic in_acc, out_free;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Note set-up values.
  logic [NRawW-1:0] n_raw;
  logic [LenW-1:0]  n_cap, att_full, att_new;
  logic [PctW-1:0]  lv_sat, vo_sat;
  assign n_raw    = NRawW'(in_dur) * NRawW'(SAMPLES_PER_MS);
  assign n_cap    = (n_raw > NRawW'(MaxN)) ? MaxN : n_raw[LenW-1:0];
  assign att_full = (n_cap >> 3) + LenW'(1);
  assign att_new  = (att_full > AttackCap) ? AttackCap : att_full;
  assign lv_sat   = (in_level > PctFull) ? PctFull : in_level;
  assign vo_sat   = (in_volume > PctFull) ? PctFull : in_volume;

  // Envelope segment of the current sample.
  logic            in_attack, in_release, last_new;
  logic [LenW:0]   idx_next;
  assign in_attack  = idx_q < att_q;
  assign in_release = (rel_q != '0) && (idx_q >= len_q - rel_q);
  assign idx_next   = (LenW + 1)'(idx_q) + (LenW + 1)'(1);
  assign last_new   = idx_next >= (LenW + 1)'(len_q);

  // Sine ROM, a quarter wave with its end point.
  logic [MagW-1:0] sine_rom [SineDepth];
  for (genvar g = 0; g < SineDepth; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(g, SINE_TABLE_BITS);
  end

  function automatic logic [SineAddrW-1:0] sine_addr(logic [31:0] ph);
    logic [SINE_TABLE_BITS-3:0] r;
    r = ph[29 -: (SINE_TABLE_BITS - 2)];
    return ph[30] ? (SineAddrW'(SineQ) - SineAddrW'(r)) : SineAddrW'(r);
  endfunction

  logic [SineAddrW-1:0] rom_addr;
  assign rom_addr = (state_q == S_ROMC) ? sine_addr(smp_c_q) : sine_addr(smp_m_q);

  // Waveform value as sign and magnitude.
  logic [31:0]     tri_d;
  logic [16:0]     tri_t;
  logic [15:0]     nv;
  logic [31:0]     ring_p;
  logic [MagW-1:0] w_mag;
  logic            w_neg;
  assign tri_d  = smp_c_q[31] ? (32'd0 - smp_c_q) : smp_c_q;
  assign tri_t  = tri_d[31:15];
  assign nv     = noise_q[31:16];
  assign ring_p = 32'(sinc_q) * 32'(rom_q);

  always_comb begin
    w_mag = FullScale;
    w_neg = smp_c_q[31];
    case (wave_e'(wave_q))
      WAVE_SINE: begin
        w_mag = sinc_q;
        w_neg = smp_c_q[31];
      end
      WAVE_NOISE: begin
        w_neg = !nv[15];
        w_mag = nv[15] ? {1'b0, nv[14:0]} : MagW'(17'h1_0000 - 17'(nv) - 17'h0_8000);
      end
      WAVE_TRIANGLE: begin
        w_neg = !tri_t[16] && !tri_t[15];
        w_mag = w_neg ? MagW'(17'h0_8000 - tri_t) : MagW'(tri_t - 17'h0_8000);
      end
      WAVE_RING: begin
        w_mag = ring_p[30:15];
        w_neg = smp_c_q[31] ^ smp_m_q[31];
      end
      default: begin
        w_mag = FullScale;
        w_neg = smp_c_q[31];
      end
    endcase
  end

  // One restoring division step.
  logic [DivW-1:0] rem_sh;
  logic            div_ge, div_done;
  assign rem_sh   = {rem_q[DivW-2:0], acc_q[DivW-1]};
  assign div_ge   = rem_sh >= dvs_q;
  assign div_done = cnt_q == CntW'(DivW - 1);

  // Saturated output sample.
  logic [MagW-1:0]    sat_mag;
  logic [SampleW-1:0] smp_out;
  always_comb begin
    if (w_neg_q) begin
      sat_mag = (acc_q > DivW'(FullScale)) ? FullScale : acc_q[MagW-1:0];
      smp_out = SampleW'(0) - sat_mag;
    end else begin
      sat_mag = (acc_q > DivW'(PosLimit)) ? PosLimit : acc_q[MagW-1:0];
      smp_out = sat_mag;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_e'(s_axis_tuser_i) == MODE_START) begin
            state_d = (n_cap == '0) ? S_IDLE : S_REL;
          end else begin
            state_d = playing_q ? S_ROMC : S_OUT;
          end
        end
      end
      S_REL:   state_d = S_DIV;
      S_ROMC:  state_d = S_ROMM;
      S_ROMM:  state_d = S_SHAPE;
      S_SHAPE: state_d = S_MULA;
      S_MULA:  state_d = S_MULB;
      S_MULB:  state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = job_rel_q ? S_RELW : S_OUT;
      end
      S_RELW:  state_d = S_IDLE;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and note state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      playing_q <= 1'b0;
      m_valid_q <= 1'b0;
      ph_c_q    <= '0;
      ph_m_q    <= '0;
      inc_q     <= '0;
      sweep_q   <= '0;
      mstep_q   <= '0;
      noise_q   <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      att_q     <= '0;
      rel_q     <= '0;
      amp_q     <= '0;
      wave_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (in_acc && mode_e'(s_axis_tuser_i) == MODE_START) begin
        playing_q <= n_cap != '0;
        if (n_cap != '0) begin
          len_q   <= n_cap;
          att_q   <= att_new;
          amp_q   <= AmpW'(lv_sat) * AmpW'(vo_sat);
          wave_q  <= in_wave;
          inc_q   <= in_carrier;
          sweep_q <= in_sweep;
          mstep_q <= in_mod;
          noise_q <= NoiseSeed + 32'(in_base);
          ph_c_q  <= '0;
          ph_m_q  <= '0;
          idx_q   <= '0;
        end
      end else if (in_acc && playing_q) begin
        ph_c_q <= ph_c_q + inc_q;
        inc_q  <= inc_q + sweep_q;
        ph_m_q <= ph_m_q + mstep_q;
        idx_q  <= idx_next[LenW-1:0];
        if (last_new) playing_q <= 1'b0;
      end

      // The noise generator steps once per noise sample.
      if (state_q == S_ROMC && wave_e'(wave_q) == WAVE_NOISE) begin
        noise_q <= noise_q * LcgMul + LcgAdd;
      end

      if (state_q == S_RELW) begin
        rel_q <= (acc_q > DivW'(len_q)) ? len_q : acc_q[LenW-1:0];
      end
    end
  end

  // Sample datapath and divider.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dp_q        <= in_decay;
          smp_c_q     <= ph_c_q;
          smp_m_q     <= ph_m_q;
          last_q      <= last_new;
          idle_tick_q <= !playing_q;
          job_rel_q   <= mode_e'(s_axis_tuser_i) == MODE_START;
          if (in_attack) begin
            e_q <= idx_q;
            d_q <= att_q;
          end else if (in_release) begin
            e_q <= len_q - idx_q;
            d_q <= rel_q;
          end else begin
            e_q <= LenW'(1);
            d_q <= LenW'(1);
          end
        end
      end
      S_REL: begin
        pa_q  <= Peak * PaW'(amp_q);
        acc_q <= (dp_q != '0) ? DivW'(len_q) * DivW'(dp_q) : DivW'(len_q);
        dvs_q <= (dp_q != '0) ? DivW'(PctFull) : DivW'(DivThird);
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_ROMC: rom_q <= sine_rom[rom_addr];
      S_ROMM: begin
        sinc_q <= rom_q;
        rom_q  <= sine_rom[rom_addr];
      end
      S_SHAPE: begin
        w_mag_q <= w_mag;
        w_neg_q <= w_neg;
      end
      S_MULA: prod_a_q <= 32'(w_mag_q) * 32'(e_q);
      S_MULB: begin
        acc_q <= DivW'(prod_a_q) * DivW'(pa_q);
        dvs_q <= DivW'(DenScale) * DivW'(d_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? (rem_sh - dvs_q) : rem_sh;
        acc_q <= {acc_q[DivW-2:0], div_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      S_OUT: begin
        if (out_free) begin
          m_data_q <= idle_tick_q ? '0 : smp_out;
          m_user_q <= !idle_tick_q;
          m_last_q <= !idle_tick_q && last_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* hw/rtl/nts_checker.sv */
// Port-level checks of the note synthesizer voice and their binding.
`include "note_tone_synth_envelope_defines.svh"

module nts_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_i,
  input logic                        m_axis_tready_i,
  // sample
  input logic [nts_pkg::SampleW-1:0] m_axis_tdata_i,
  // note_active
  input logic                        m_axis_tuser_i,
  input logic                        m_axis_tlast_i
);
  import nts_pkg::*;

  // A stalled output item holds.
  `NTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i) && $stable(m_axis_tlast_i))

  // An item outside a note is silent.
  `NTS_ASSERT_SAME(a_idle_silent, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tuser_i, m_axis_tdata_i == '0)

  // Only a sample of a playing note can close it.
  `NTS_ASSERT_SAME(a_last_active, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tlast_i, m_axis_tuser_i)

endmodule

bind note_tone_synth_envelope nts_checker u_nts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

/* tb/sv/tb.sv */
// Self-checking testbench of the note synthesizer voice with its own sample predictor.
`timescale 1ns / 100ps

module tb;
  import nts_pkg::*;

  localparam int unsigned TotalItems = 2000;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned QuietTail  = 300;

  typedef struct {
    mode_e       mode;
    logic [2:0]  wave;
    logic [31:0] carrier_inc;
    logic [31:0] sweep;
    logic [31:0] mod_inc;
    logic [15:0] base_freq;
    logic [15:0] dur_ms;
    logic [6:0]  level;
    logic [6:0]  volume;
    logic [6:0]  decay;
  } note_item_t;

  typedef struct {
    logic [15:0] sample;
    logic        active;
    logic        last;
  } voice_out_t;

  logic clk_i;
  logic rst_ni;
  logic s_tvalid;
  logic s_tready;
  logic [InDataW-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [SampleW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  note_item_t items_pending[$];
  note_item_t item_on_bus;
  voice_out_t samples_due[$];
  int         sine_rom[0:256];
  int unsigned items_taken;
  int unsigned errors;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_cycles;
  bit          hold_done;
  bit          took;

  // Voice state as the predictor sees it.
  logic [31:0] v_phase, v_mphase, v_inc, v_sweep, v_minc, v_noise;
  int unsigned v_index, v_len, v_attack, v_release, v_amp;
  logic [2:0]  v_wave;
  bit          v_playing;

  note_tone_synth_envelope uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Quarter sine table, round(32768*sin) in a Q2.30 Taylor series.
  function automatic int qsine(int unsigned k);
    longint x, x2, term, acc;
    x    = (64'sd1686629713 * longint'(k)) / 256;
    x2   = (x * x) / 64'sd1073741824;
    term = x;
    acc  = x;
    for (int j = 1; j <= 8; j++) begin
      term = (term * x2) / 64'sd1073741824;
      term = -(term / longint'((2 * j) * (2 * j + 1)));
      acc  = acc + term;
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    return int'((acc + 16384) / 32768);
  endfunction

  function automatic int sine_at(logic [31:0] phase);
    logic [9:0] idx;
    int unsigned k;
    idx = phase[31:22];
    k   = idx[8] ? 256 - idx[7:0] : idx[7:0];
    return idx[9] ? -sine_rom[k] : sine_rom[k];
  endfunction

  function automatic logic [InDataW-1:0] pack_item(note_item_t it);
    return {it.decay, it.volume, it.level, it.dur_ms, it.base_freq,
            it.mod_inc, it.sweep, it.carrier_inc, it.wave};
  endfunction

  // Works out the sample, if any, that an accepted item causes.
  function automatic void voice_predict(note_item_t it);
    int unsigned n, lv, vo, e, d, mag;
    int          w;
    logic [31:0] tri_d;
    logic [63:0] num, den, qv;
    voice_out_t  r;
    if (it.mode == MODE_START) begin
      n  = it.dur_ms * 16;
      if (n > 32000) n = 32000;
      lv = (it.level > 100) ? 100 : it.level;
      vo = (it.volume > 100) ? 100 : it.volume;
      v_playing = 1'b0;
      if (n == 0) return;
      v_len    = n;
      v_attack = n / 8 + 1;
      if (v_attack > 64) v_attack = 64;
      v_release = (it.decay != 0) ? (n * it.decay) / 100 : n / 3;
      if (v_release > n) v_release = n;
      v_amp     = lv * vo;
      v_wave    = it.wave;
      v_inc     = it.carrier_inc;
      v_sweep   = it.sweep;
      v_minc    = it.mod_inc;
      v_noise   = NoiseSeed + it.base_freq;
      v_phase   = '0;
      v_mphase  = '0;
      v_index   = 0;
      v_playing = 1'b1;
      return;
    end
    if (!v_playing) begin
      r = '{16'd0, 1'b0, 1'b0};
      samples_due.push_back(r);
      return;
    end
    case (v_wave)
      WAVE_SINE: w = sine_at(v_phase);
      WAVE_NOISE: begin
        v_noise = v_noise * LcgMul + LcgAdd;
        w = int'(v_noise[31:16]) - 32768;
      end
      WAVE_TRIANGLE: begin
        tri_d = v_phase[31] ? 32'd0 - v_phase : v_phase;
        if (v_phase == 32'h8000_0000) tri_d = 32'h8000_0000;
        w = int'(tri_d >> 15) - 32768;
      end
      WAVE_RING: w = (sine_at(v_phase) * sine_at(v_mphase)) / 32768;
      default: w = v_phase[31] ? -32768 : 32768;
    endcase
    v_phase  = v_phase + v_inc;
    v_inc    = v_inc + v_sweep;
    v_mphase = v_mphase + v_minc;
    e = 1;
    d = 1;
    if (v_index < v_attack) begin
      e = v_index;
      d = v_attack;
    end else if (v_index >= v_len - v_release && v_release != 0) begin
      e = v_len - v_index;
      d = v_release;
    end
    mag = (w < 0) ? -w : w;
    num = 64'(mag) * 64'(e) * (64'd9000 * 64'(v_amp));
    den = 64'd32768 * 64'(d) * 64'd10000;
    qv  = num / den;
    if (w < 0) begin
      if (qv > 32768) qv = 32768;
      r.sample = 16'(-int'(qv));
    end else begin
      if (qv > 32767) qv = 32767;
      r.sample = 16'(qv);
    end
    r.active = 1'b1;
    r.last   = (v_index + 1 >= v_len);
    samples_due.push_back(r);
    v_index = v_index + 1;
    if (v_index >= v_len) v_playing = 1'b0;
  endfunction

  function automatic note_item_t random_note(int unsigned dur);
    note_item_t it;
    it.mode        = MODE_START;
    it.wave        = 3'($urandom_range(0, 7));
    it.carrier_inc = $urandom();
    it.sweep       = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom();
    it.mod_inc     = $urandom();
    it.base_freq   = 16'($urandom());
    it.dur_ms      = 16'(dur);
    it.level       = ($urandom_range(0, 3) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 100));
    it.volume      = ($urandom_range(0, 3) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 100));
    it.decay       = ($urandom_range(0, 3) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 100));
    return it;
  endfunction

  function automatic void add_ticks(int unsigned count);
    note_item_t t;
    t = random_note(0);
    t.mode = MODE_TICK;
    for (int unsigned i = 0; i < count; i++) begin
      t.wave = 3'($urandom());
      items_pending.push_back(t);
    end
  endfunction

  // Item sender: changes on the falling edge, with random bursts of idling.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || took)) begin
      took = 1'b0;
      if (send_gap == 0 && items_pending.size() > QuietTail && $urandom_range(0, 9) == 0)
        send_gap = $urandom_range(1, 14);
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (items_pending.size() != 0) begin
        item_on_bus = items_pending.pop_front();
        s_tdata  <= pack_item(item_on_bus);
        s_tuser  <= item_on_bus.mode;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sample receiver: one long hold-off early on, random stalls otherwise.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && items_taken >= 150) begin
        if (hold_cycles < 3000) begin
          hold_cycles = hold_cycles + 1;
          m_tready <= 1'b0;
        end else begin
          hold_done = 1'b1;
          m_tready <= 1'b1;
        end
      end else begin
        if (recv_gap == 0 && items_pending.size() > QuietTail && $urandom_range(0, 9) == 0)
          recv_gap = $urandom_range(1, 14);
        if (recv_gap != 0) begin
          recv_gap = recv_gap - 1;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Accept monitor, sample checker and cycle limit.
  always @(posedge clk_i) begin
    voice_out_t want;
    if (rst_ni) begin
      cycles = cycles + 1;
      if (cycles > CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (s_tvalid && s_tready) begin
        voice_predict(item_on_bus);
        items_taken = items_taken + 1;
        took = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (samples_due.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected sample, actual %h/%b/%b", $time, m_tdata, m_tuser,
                   m_tlast);
        end else begin
          want = samples_due.pop_front();
          if (m_tdata !== want.sample) begin
            errors = errors + 1;
            $display("%0t: sample expected %h actual %h", $time, want.sample, m_tdata);
          end
          if (m_tuser !== want.active) begin
            errors = errors + 1;
            $display("%0t: note_active expected %b actual %b", $time, want.active, m_tuser);
          end
          if (m_tlast !== want.last) begin
            errors = errors + 1;
            $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    note_item_t it;
    int unsigned dur;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    m_tready = 1'b0;
    rst_ni   = 1'b0;
    took     = 1'b0;
    items_taken = 0;
    errors   = 0;
    cycles   = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_cycles = 0;
    hold_done   = 1'b0;
    v_phase = '0; v_mphase = '0; v_inc = '0; v_sweep = '0; v_minc = '0; v_noise = '0;
    v_index = 0; v_len = 0; v_attack = 0; v_release = 0; v_amp = 0;
    v_wave = '0; v_playing = 1'b0;
    for (int k = 0; k <= 256; k++) sine_rom[k] = qsine(k);

    // Directed: idle ticks, every waveform, field extremes, abandoned notes.
    add_ticks(2);
    it = random_note(1);
    it.wave = WAVE_SQUARE; it.carrier_inc = 32'hFFFF_FFFF; it.sweep = 32'h8000_0000;
    it.level = 7'h7F; it.volume = 7'h7F; it.decay = 7'd0;
    items_pending.push_back(it);
    add_ticks(17);
    for (int wv = 1; wv < 8; wv++) begin
      it = random_note(1);
      it.wave = 3'(wv);
      it.sweep = (wv == 3) ? 32'h7FFF_FFFF : 32'd0;
      it.carrier_inc = (wv == 1) ? 32'd0 : it.carrier_inc;
      it.base_freq = (wv == 2) ? 16'hFFFF : 16'd0;
      it.level = 7'd100; it.volume = (wv == 5) ? 7'd0 : 7'd100;
      it.decay = (wv == 4) ? 7'h7F : 7'd100;
      items_pending.push_back(it);
      add_ticks(16);
    end
    it = random_note(16'hFFFF);
    items_pending.push_back(it);
    add_ticks(5);
    it = random_note(0);
    items_pending.push_back(it);
    add_ticks(2);

    // Random: mostly whole short notes, some cut short, some stray ticks.
    while (items_pending.size() < TotalItems) begin
      case ($urandom_range(0, 9))
        0: dur = 0;
        1: dur = $urandom_range(0, 65535);
        default: dur = $urandom_range(1, 3);
      endcase
      items_pending.push_back(random_note(dur));
      dur = (dur * 16 > 32000) ? 32000 : dur * 16;
      if ($urandom_range(0, 4) == 0 || dur > 48) add_ticks($urandom_range(0, 10));
      else add_ticks(dur + $urandom_range(0, 2));
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (items_pending.size() == 0 && !s_tvalid);
    wait (samples_due.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nts_pkg.sv
hw/rtl/note_tone_synth_envelope.sv
hw/rtl/nts_checker.sv
tb/sv/tb.sv
